@@ design/mwrm_pkg.sv @@
// Shared constants and types for the moving window rate meter.
package mwrm_pkg;

	localparam int WINDOW_DEPTH = 2048;
	localparam int IDX_W = $clog2(WINDOW_DEPTH);
	localparam int CNT_W = IDX_W + 1;
	localparam int WIN_W = 12;
	localparam int FPS_CFG_W = 8;
	localparam int TS_W = 48;
	localparam int BYTES_W = 32;
	localparam int TOTAL_W = 43;
	localparam int FPS_W = 32;
	localparam int KBPS_W = 40;
	localparam int NUM_W = 64;
	localparam int QUO_W = 40;
	localparam int BITS_W = 7;
	localparam int PCNT_W = 32;

	localparam int MUL_STEPS = 21;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS);
	localparam logic [MUL_STEPS-1:0] RATE_SCALE = 21'd2000000;

	localparam int FPS_SHIFT = 7;
	localparam logic [BITS_W-1:0] FPS_NUM_BITS = BITS_W'(PCNT_W + FPS_SHIFT);
	localparam logic [BITS_W-1:0] KBPS_NUM_BITS = BITS_W'(NUM_W);

	localparam logic [WIN_W-1:0] WIN_RESET = 12'd1920;
	localparam logic [FPS_CFG_W-1:0] FPS_RESET = 8'd30;

	typedef enum logic {
		OP_ADD   = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	typedef enum logic {
		REG_WINDOW_SIZE = 1'b0,
		REG_DEFAULT_FPS = 1'b1
	} reg_sel_t;

	typedef struct packed {
		logic start;
		logic [BITS_W-1:0] nbits;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic ovf;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

endpackage

@@ design/mwrm_div.sv @@
// Bit-serial restoring divider with quotient overflow flag.
module mwrm_div
	import mwrm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  div_req_t            req,
	input  logic [NUM_W-1:0]    numer,
	input  logic [TS_W-1:0]     divisor,
	output div_rsp_t            rsp
);

	logic [NUM_W-1:0]  num_q;
	logic [TS_W-1:0]   rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic              ovf_q;
	logic [BITS_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [TS_W:0] rem_ext;
	logic [TS_W:0] diff;
	logic          ge;

	assign rem_ext = {rem_q, num_q[NUM_W-1]};
	assign diff    = rem_ext - {1'b0, divisor};
	assign ge      = !diff[TS_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				num_q  <= numer;
				rem_q  <= '0;
				quo_q  <= '0;
				ovf_q  <= 1'b0;
				cnt_q  <= req.nbits;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				num_q <= num_q << 1;
				rem_q <= ge ? diff[TS_W-1:0] : rem_ext[TS_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], ge};
				ovf_q <= ovf_q | quo_q[QUO_W-1];
				cnt_q <= cnt_q - BITS_W'(1);
				if (cnt_q == BITS_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.ovf  = ovf_q;
	assign rsp.quo  = quo_q;

endmodule

@@ design/moving_window_rate_meter.sv @@
// Top level of the moving window frame rate and bit rate meter.
//
// channel   dir   handshake                    payload
// config    in    psel/penable/pwrite/pready   paddr, pwdata, prdata
// item      in    item_valid/item_ready        operation, timestamp_us, frame_bytes
// result    out   result_valid/result_ready    frames_in_window, fps_x256, kbps_x256
//
// An add passes through ring access and span, the serial multiplier, the two divider passes
// (frame rate, then bit rate) and the result load, then returns to idle. A clear goes straight
// to the result load; an add with zero time span skips the multiplier and both divider passes.
// The result register frees the input side: the next word is taken while a result waits,
// and its own result then holds in the finish state until result_ready.
// Reset restores the registers and empties the window; ring entries are never cleared.
module moving_window_rate_meter
	import mwrm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  logic                 operation,
	input  logic [TS_W-1:0]      timestamp_us,
	input  logic [BYTES_W-1:0]   frame_bytes,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [CNT_W-1:0]     frames_in_window,
	output logic [FPS_W-1:0]     fps_x256,
	output logic [KBPS_W-1:0]    kbps_x256
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_SIZE,
		ST_UPDATE,
		ST_WRITE,
		ST_RD_TIME,
		ST_SPAN,
		ST_MUL,
		ST_DIVF_GO,
		ST_DIVF_WAIT,
		ST_DIVK_GO,
		ST_DIVK_WAIT,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [WIN_W-1:0]     window_size_q;
	logic [FPS_CFG_W-1:0] default_fps_q;

	logic [IDX_W-1:0]   oldest_q;
	logic [CNT_W-1:0]   frame_count_q;
	logic [TOTAL_W-1:0] byte_total_q;

	logic [TS_W-1:0]      ts_q;
	logic [BYTES_W-1:0]   bytes_q;
	logic                 drop_q;
	logic                 zero_q;
	logic [TS_W-1:0]      dt_q;
	logic [MUL_CNT_W-1:0] mul_cnt_q;
	logic [PCNT_W-1:0]    prod_cnt_q;
	logic [NUM_W-1:0]     prod_tot_q;
	logic [FPS_W-1:0]     fps_q;
	logic [KBPS_W-1:0]    kbps_q;

	logic                 result_valid_q;
	logic [CNT_W-1:0]     res_count_q;
	logic [FPS_W-1:0]     res_fps_q;
	logic [KBPS_W-1:0]    res_kbps_q;

	logic [TS_W-1:0]    time_mem [WINDOW_DEPTH];
	logic [BYTES_W-1:0] size_mem [WINDOW_DEPTH];
	logic [TS_W-1:0]    time_rd_q;
	logic [BYTES_W-1:0] size_rd_q;

	logic [CNT_W-1:0] win_eff;
	logic [IDX_W-1:0] wr_idx;
	logic [TS_W-1:0]  dt_c;
	logic             cfg_wr;
	div_req_t         div_req;
	div_rsp_t         div_rsp;
	logic [NUM_W-1:0] div_numer;

	assign pready     = 1'b1;
	assign cfg_wr     = psel && penable && pwrite;
	assign item_ready = (state_q == ST_IDLE);

	always_comb begin
		if (window_size_q == '0) begin
			win_eff = CNT_W'(1);
		end else if (CNT_W'(window_size_q) > CNT_W'(WINDOW_DEPTH)) begin
			win_eff = CNT_W'(WINDOW_DEPTH);
		end else begin
			win_eff = CNT_W'(window_size_q);
		end
	end

	assign wr_idx = oldest_q + frame_count_q[IDX_W-1:0];
	assign dt_c   = ts_q - time_rd_q;

	always_comb begin
		case (reg_sel_t'(paddr[2]))
			REG_WINDOW_SIZE: prdata = 32'(window_size_q);
			REG_DEFAULT_FPS: prdata = 32'(default_fps_q);
			default:         prdata = '0;
		endcase
	end

	always_comb begin
		div_req.start = (state_q == ST_DIVF_GO) || (state_q == ST_DIVK_GO);
		if (state_q == ST_DIVK_GO) begin
			div_req.nbits = KBPS_NUM_BITS;
			div_numer     = prod_tot_q;
		end else begin
			div_req.nbits = FPS_NUM_BITS;
			div_numer     = {prod_cnt_q, {(NUM_W - PCNT_W){1'b0}}};
		end
	end

	mwrm_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (div_req),
		.numer   (div_numer),
		.divisor (dt_q),
		.rsp     (div_rsp)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE) begin
			time_mem[wr_idx] <= ts_q;
			size_mem[wr_idx] <= bytes_q;
		end
		if (state_q == ST_RD_SIZE) begin
			size_rd_q <= size_mem[oldest_q];
		end
		if (state_q == ST_RD_TIME) begin
			time_rd_q <= time_mem[oldest_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			window_size_q  <= WIN_RESET;
			default_fps_q  <= FPS_RESET;
			oldest_q       <= '0;
			frame_count_q  <= '0;
			byte_total_q   <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (reg_sel_t'(paddr[2]))
					REG_WINDOW_SIZE: window_size_q <= pwdata[WIN_W-1:0];
					REG_DEFAULT_FPS: default_fps_q <= pwdata[FPS_CFG_W-1:0];
					default: ;
				endcase
			end
			if (result_valid_q && result_ready && state_q != ST_FINISH) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						ts_q    <= timestamp_us;
						bytes_q <= frame_bytes;
						if (operation == OP_CLEAR) begin
							frame_count_q <= '0;
							byte_total_q  <= '0;
							oldest_q      <= '0;
							zero_q        <= 1'b1;
							state_q       <= ST_FINISH;
						end else begin
							drop_q  <= (frame_count_q >= win_eff);
							state_q <= ST_RD_SIZE;
						end
					end
				end
				ST_RD_SIZE: state_q <= ST_UPDATE;
				ST_UPDATE: begin
					if (drop_q) begin
						byte_total_q  <= byte_total_q - TOTAL_W'(size_rd_q);
						oldest_q      <= oldest_q + IDX_W'(1);
						frame_count_q <= frame_count_q - CNT_W'(1);
					end
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					byte_total_q  <= byte_total_q + TOTAL_W'(bytes_q);
					frame_count_q <= frame_count_q + CNT_W'(1);
					state_q       <= ST_RD_TIME;
				end
				ST_RD_TIME: state_q <= ST_SPAN;
				ST_SPAN: begin
					dt_q       <= dt_c;
					zero_q     <= (dt_c == '0);
					mul_cnt_q  <= MUL_CNT_W'(MUL_STEPS - 1);
					prod_cnt_q <= '0;
					prod_tot_q <= '0;
					state_q    <= (dt_c == '0) ? ST_FINISH : ST_MUL;
				end
				ST_MUL: begin
					prod_cnt_q <= (prod_cnt_q << 1)
						+ (RATE_SCALE[mul_cnt_q] ? PCNT_W'(frame_count_q) : '0);
					prod_tot_q <= (prod_tot_q << 1)
						+ (RATE_SCALE[mul_cnt_q] ? NUM_W'(byte_total_q) : '0);
					mul_cnt_q  <= mul_cnt_q - MUL_CNT_W'(1);
					if (mul_cnt_q == '0) begin
						state_q <= ST_DIVF_GO;
					end
				end
				ST_DIVF_GO: state_q <= ST_DIVF_WAIT;
				ST_DIVF_WAIT: begin
					if (div_rsp.done) begin
						fps_q   <= (div_rsp.quo[QUO_W-1:FPS_W] != '0) ? '1
							: div_rsp.quo[FPS_W-1:0];
						state_q <= ST_DIVK_GO;
					end
				end
				ST_DIVK_GO: state_q <= ST_DIVK_WAIT;
				ST_DIVK_WAIT: begin
					if (div_rsp.done) begin
						kbps_q  <= div_rsp.ovf ? '1 : KBPS_W'(div_rsp.quo);
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!result_valid_q || result_ready) begin
						result_valid_q <= 1'b1;
						res_count_q    <= frame_count_q;
						res_fps_q      <= zero_q ? FPS_W'({default_fps_q, 8'b0}) : fps_q;
						res_kbps_q     <= zero_q ? '0 : kbps_q;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid     = result_valid_q;
	assign frames_in_window = res_count_q;
	assign fps_x256         = res_fps_q;
	assign kbps_x256        = res_kbps_q;

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && operation == OP_CLEAR) |=> (frame_count_q == '0))
		else $error("window not empty after clear");

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIVF_WAIT || state_q == ST_DIVK_WAIT))
		else $error("divider finished outside a wait state");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> (frame_count_q <= CNT_W'(WINDOW_DEPTH)))
		else $error("frame count beyond ring depth");

endmodule

@@ sim/tb.sv @@
// Testbench for the moving window rate meter: queued frame words, a window predictor and a result checker.
`timescale 1ns / 100ps

module tb;
	import mwrm_pkg::*;

	localparam logic [127:0] FPS_SCALE = 128'd256000000;
	localparam logic [127:0] KBPS_SCALE = 128'd2000000;
	localparam logic [127:0] FPS_MAX = 128'hFFFF_FFFF;
	localparam logic [127:0] KBPS_MAX = 128'hFF_FFFF_FFFF;
	localparam int IDLE_PCT = 37;
	localparam int SETTLE_CYCLES = 160;
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_AT = 150;
	localparam int HOLD_CYCLES = 700;

	typedef enum {STEP_VIDEO, STEP_BURST, STEP_WILD, STEP_STILL} ts_pace_t;

	typedef struct {
		logic op;
		logic [TS_W-1:0] stamp;
		logic [BYTES_W-1:0] nbytes;
	} frame_word_t;

	typedef struct {
		logic [CNT_W-1:0] frames;
		logic [FPS_W-1:0] fps;
		logic [KBPS_W-1:0] kbps;
	} rate_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic item_valid = 1'b0;
	logic item_ready;
	logic operation = 1'b0;
	logic [TS_W-1:0] timestamp_us = '0;
	logic [BYTES_W-1:0] frame_bytes = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic [CNT_W-1:0] frames_in_window;
	logic [FPS_W-1:0] fps_x256;
	logic [KBPS_W-1:0] kbps_x256;

	frame_word_t pending_words[$];
	rate_report_t expected_reports[$];
	frame_word_t next_word;
	rate_report_t want;

	logic [TS_W-1:0] ring_ts [WINDOW_DEPTH];
	logic [BYTES_W-1:0] ring_bytes [WINDOW_DEPTH];
	logic [IDX_W-1:0] oldest_slot;
	logic [CNT_W-1:0] held_frames;
	logic [TOTAL_W-1:0] window_bytes;
	logic [WIN_W-1:0] cfg_window;
	logic [FPS_CFG_W-1:0] cfg_fps;

	logic [TS_W-1:0] ts_cursor = '0;
	logic steady = 1'b0;
	int errors = 0;
	int results_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	moving_window_rate_meter i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.operation(operation),
		.timestamp_us(timestamp_us),
		.frame_bytes(frame_bytes),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.frames_in_window(frames_in_window),
		.fps_x256(fps_x256),
		.kbps_x256(kbps_x256)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic rate_report_t advance_window(frame_word_t w);
		logic [CNT_W-1:0] limit;
		logic [IDX_W-1:0] slot;
		logic [TS_W-1:0] span;
		logic [127:0] quo;
		rate_report_t r;
		if (cfg_window == '0) begin
			limit = CNT_W'(1);
		end else if (cfg_window > WINDOW_DEPTH) begin
			limit = CNT_W'(WINDOW_DEPTH);
		end else begin
			limit = cfg_window;
		end
		if (w.op == OP_CLEAR) begin
			held_frames = '0;
			window_bytes = '0;
			oldest_slot = '0;
		end else begin
			if (held_frames >= limit) begin
				window_bytes = window_bytes - TOTAL_W'(ring_bytes[oldest_slot]);
				oldest_slot = oldest_slot + 1'b1;
				held_frames = held_frames - 1'b1;
			end
			slot = oldest_slot + held_frames[IDX_W-1:0];
			ring_ts[slot] = w.stamp;
			ring_bytes[slot] = w.nbytes;
			window_bytes = window_bytes + TOTAL_W'(w.nbytes);
			held_frames = held_frames + 1'b1;
		end
		span = '0;
		if (held_frames != '0) begin
			slot = oldest_slot + held_frames[IDX_W-1:0] - 1'b1;
			span = ring_ts[slot] - ring_ts[oldest_slot];
		end
		r.frames = held_frames;
		if (span == '0) begin
			r.fps = FPS_W'({cfg_fps, 8'h00});
			r.kbps = '0;
		end else begin
			quo = FPS_SCALE * 128'(held_frames) / 128'(span);
			r.fps = (quo > FPS_MAX) ? '1 : quo[FPS_W-1:0];
			quo = KBPS_SCALE * 128'(window_bytes) / 128'(span);
			r.kbps = (quo > KBPS_MAX) ? '1 : quo[KBPS_W-1:0];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			operation <= OP_ADD;
			timestamp_us <= '0;
			frame_bytes <= '0;
		end else begin
			if (item_valid && item_ready) begin
				expected_reports.insert(expected_reports.size(),
					advance_window('{operation, timestamp_us, frame_bytes}));
			end
			if (!item_valid || item_ready) begin
				if (pending_words.size() != 0 && (steady || $urandom_range(99, 0) >= IDLE_PCT)) begin
					next_word = pending_words[0];
					pending_words.delete(0);
					item_valid <= 1'b1;
					operation <= next_word.op;
					timestamp_us <= next_word.stamp;
					frame_bytes <= next_word.nbytes;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_reports.size() == 0) begin
					$display("%0t ns: unexpected result: frames %0d fps %0d kbps %0d", $time,
						frames_in_window, fps_x256, kbps_x256);
					errors++;
				end else begin
					want = expected_reports[0];
					expected_reports.delete(0);
					if (frames_in_window !== want.frames) begin
						$display("%0t ns: frames_in_window expected %0d, actual %0d", $time,
							want.frames, frames_in_window);
						errors++;
					end
					if (fps_x256 !== want.fps) begin
						$display("%0t ns: fps_x256 expected %0d, actual %0d", $time,
							want.fps, fps_x256);
						errors++;
					end
					if (kbps_x256 !== want.kbps) begin
						$display("%0t ns: kbps_x256 expected %0d, actual %0d", $time,
							want.kbps, kbps_x256);
						errors++;
					end
				end
				results_seen++;
				if (results_seen == HOLD_AT) begin
					hold_left = HOLD_CYCLES;
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= steady || ($urandom_range(99, 0) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic void queue_frame(logic op, logic [TS_W-1:0] stamp,
		logic [BYTES_W-1:0] nbytes);
		frame_word_t w;
		w = '{op, stamp, nbytes};
		pending_words.insert(pending_words.size(), w);
	endfunction

	task automatic wait_until_drained();
		do @(negedge clk);
		while (pending_words.size() != 0 || item_valid || expected_reports.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_register(input reg_sel_t sel, input logic [31:0] value);
		logic [31:0] want_rd;
		want_rd = (sel == REG_WINDOW_SIZE) ? {20'b0, value[WIN_W-1:0]}
			: {24'b0, value[FPS_CFG_W-1:0]};
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		if (sel == REG_WINDOW_SIZE) begin
			cfg_window = value[WIN_W-1:0];
		end else begin
			cfg_fps = value[FPS_CFG_W-1:0];
		end
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		if (prdata !== want_rd) begin
			$display("%0t ns: register %0d readback expected %0d, actual %0d", $time,
				sel, want_rd, prdata);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_phase(int count, ts_pace_t pace, int clear_pct, bit calm);
		logic op;
		logic [BYTES_W-1:0] nbytes;
		int pick;
		steady = calm;
		for (int k = 0; k < count; k++) begin
			op = ($urandom_range(99, 0) < clear_pct) ? OP_CLEAR : OP_ADD;
			case (pace)
				STEP_VIDEO: ts_cursor = ts_cursor + $urandom_range(70000, 0);
				STEP_BURST: ts_cursor = ts_cursor + ($urandom_range(3, 0) == 0);
				STEP_WILD: begin
					if ($urandom_range(9, 0) == 0) begin
						ts_cursor = TS_W'({$urandom, $urandom});
					end else begin
						ts_cursor = ts_cursor + $urandom_range(2000000, 0);
					end
				end
				default: ;
			endcase
			pick = $urandom_range(9, 0);
			if (pick == 0) begin
				nbytes = '0;
			end else if (pick == 1) begin
				nbytes = '1;
			end else if (pick < 5) begin
				nbytes = $urandom;
			end else begin
				nbytes = $urandom_range(300000, 1);
			end
			queue_frame(op, ts_cursor, nbytes);
		end
		wait_until_drained();
		steady = 1'b0;
	endtask

	initial begin
		oldest_slot = '0;
		held_frames = '0;
		window_bytes = '0;
		cfg_window = WIN_RESET;
		cfg_fps = FPS_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		queue_frame(OP_ADD, 48'h0, 32'h0);
		queue_frame(OP_ADD, 48'h0, 32'hFFFF_FFFF);
		queue_frame(OP_ADD, 48'h1, 32'hFFFF_FFFF);
		queue_frame(OP_ADD, 48'hFFFF_FFFF_FFFF, 32'h0001_2345);
		queue_frame(OP_ADD, 48'h5, 32'h8000_0000);
		queue_frame(OP_CLEAR, 48'h5, 32'h0);
		queue_frame(OP_CLEAR, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		queue_frame(OP_ADD, 48'hFFFF_FFFF_FFF0, 32'd1000);
		queue_frame(OP_ADD, 48'h10, 32'd2000);
		queue_frame(OP_ADD, 48'h0000_8000_0000, 32'd77);
		wait_until_drained();

		set_register(REG_WINDOW_SIZE, 32'd0);
		set_register(REG_DEFAULT_FPS, 32'd255);
		queue_frame(OP_ADD, 48'd100, 32'd500);
		queue_frame(OP_ADD, 48'd200, 32'd600);
		queue_frame(OP_CLEAR, 48'd200, 32'd0);
		queue_frame(OP_ADD, 48'd300, 32'hFFFF_FFFF);
		wait_until_drained();

		set_register(REG_WINDOW_SIZE, 32'd4095);
		set_register(REG_DEFAULT_FPS, 32'd0);
		queue_frame(OP_ADD, 48'd7, 32'd9);
		queue_frame(OP_ADD, 48'd7, 32'd9);
		queue_frame(OP_ADD, 48'd8, 32'd1);
		wait_until_drained();

		set_register(REG_WINDOW_SIZE, 32'd2);
		queue_frame(OP_ADD, 48'd1000, 32'd4000);
		queue_frame(OP_ADD, 48'd2000, 32'd5000);
		queue_frame(OP_ADD, 48'd3000, 32'd6000);
		wait_until_drained();

		set_register(REG_WINDOW_SIZE, 32'd3);
		set_register(REG_DEFAULT_FPS, $urandom_range(255, 0));
		run_phase(100, STEP_VIDEO, 4, 1'b0);

		set_register(REG_WINDOW_SIZE, 32'd24);
		set_register(REG_DEFAULT_FPS, 32'd0);
		run_phase(120, STEP_BURST, 3, 1'b0);

		set_register(REG_WINDOW_SIZE, 32'd40);
		run_phase(70, STEP_VIDEO, 0, 1'b0);
		set_register(REG_WINDOW_SIZE, 32'd5);
		run_phase(60, STEP_VIDEO, 3, 1'b0);

		set_register(REG_WINDOW_SIZE, 32'd1);
		set_register(REG_DEFAULT_FPS, 32'd255);
		run_phase(60, STEP_WILD, 5, 1'b0);

		for (int p = 0; p < 3; p++) begin
			set_register(REG_WINDOW_SIZE, $urandom_range(64, 1));
			set_register(REG_DEFAULT_FPS, $urandom_range(255, 0));
			run_phase(80, ts_pace_t'(p), 4, p == 1);
		end

		set_register(REG_WINDOW_SIZE, 32'd4095);
		set_register(REG_DEFAULT_FPS, $urandom_range(255, 0));
		queue_frame(OP_CLEAR, ts_cursor, 32'd0);
		run_phase(20, STEP_STILL, 0, 1'b0);
		run_phase(10, STEP_VIDEO, 0, 1'b0);

		set_register(REG_WINDOW_SIZE, 32'd1920);
		set_register(REG_DEFAULT_FPS, 32'd30);
		run_phase(60, STEP_VIDEO, 4, 1'b0);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && expected_reports.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
